@@ rtl/core/keyed_record_list_table_assert.svh @@
// Assertion macros shared by the table modules.
// Both expect clk_i and rst_ni in scope.
`ifndef KEYED_RECORD_LIST_TABLE_ASSERT_SVH
`define KEYED_RECORD_LIST_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define KRLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("krlt: assertion failed");
`define KRLT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("krlt: reset assertion failed");
`else
`define KRLT_ASSERT(lbl, prop)
`define KRLT_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/core/krlt_pkg.sv @@
`timescale 1ns / 1ps
package krlt_pkg;

  localparam int CAP   = 16;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  localparam int OP_W    = 2;
  localparam int KEY_W   = 27;
  localparam int YEAR_W  = 14;
  localparam int AGE_W   = 8;
  localparam int NAMEL_W = 64;
  localparam int NAMEH_W = 16;
  localparam int INFO_W  = YEAR_W + AGE_W;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IN_BITS    = KEY_W + YEAR_W + AGE_W + NAMEL_W + NAMEH_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = COUNT_W + KEY_W + YEAR_W + AGE_W + NAMEL_W + NAMEH_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic load;    // capture an incoming request
    logic commit;  // update the table and load the result register
  } cmd_t;

endpackage

@@ rtl/core/krlt_ctrl.sv @@
`timescale 1ns / 1ps
`include "keyed_record_list_table_assert.svh"
module krlt_ctrl
  import krlt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = in_valid_i && (state_q == S_IDLE);
    // hold in EXEC until the result register is free or drains this cycle
    cmd_o.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `KRLT_ASSERT_RST(a_idle_in_reset, !rst_ni |-> (state_q == S_IDLE) && !out_valid_q)
  `KRLT_ASSERT(a_load_enters_exec, cmd_o.load |=> (state_q == S_EXEC))
  `KRLT_ASSERT(a_commit_gives_result, cmd_o.commit |=> out_valid_q)
  `KRLT_ASSERT(a_result_held, out_valid_q && !out_ready_i && !cmd_o.commit |=> out_valid_q)

endmodule

@@ rtl/core/krlt_dp.sv @@
`timescale 1ns / 1ps
`include "keyed_record_list_table_assert.svh"
module krlt_dp
  import krlt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [OP_W-1:0]      op_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [YEAR_W-1:0]    year_i,
  input  logic [AGE_W-1:0]     age_i,
  input  logic [NAMEL_W-1:0]   name_low_i,
  input  logic [NAMEH_W-1:0]   name_high_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [COUNT_W-1:0]   count_o,
  output logic [KEY_W-1:0]     found_key_o,
  output logic [YEAR_W-1:0]    found_year_o,
  output logic [AGE_W-1:0]     found_age_o,
  output logic [NAMEL_W-1:0]   found_name_low_o,
  output logic [NAMEH_W-1:0]   found_name_high_o
);

  // captured request
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [YEAR_W-1:0]  year_q;
  logic [AGE_W-1:0]   age_q;
  logic [NAMEL_W-1:0] name_low_q;
  logic [NAMEH_W-1:0] name_high_q;

  // record storage
  logic [KEY_W-1:0]   key_mem_q   [CAP];
  logic [INFO_W-1:0]  info_mem_q  [CAP];
  logic [NAMEL_W-1:0] namel_mem_q [CAP];
  logic [NAMEH_W-1:0] nameh_mem_q [CAP];
  logic [CNT_W-1:0]   count_q, count_d;

  logic [CAP-1:0]     hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               any_hit;
  logic               full;
  logic               do_insert;
  logic               do_shift;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic [STAT_W-1:0]  status_d;
  logic [KEY_W-1:0]   fkey_d;
  logic [INFO_W-1:0]  finfo_d;
  logic [NAMEL_W-1:0] fnamel_d;
  logic [NAMEH_W-1:0] fnameh_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= op_i;
      key_q       <= key_i;
      year_q      <= year_i;
      age_q       <= age_i;
      name_low_q  <= name_low_i;
      name_high_q <= name_high_i;
    end
  end

  // compare all live entries at once, keep the one nearest the head
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      hit[i] = (CNT_W'(i) < count_q) && (key_mem_q[i] == key_q);
    end
    hit_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = IDX_W'(i);
    end
    any_hit = |hit;
  end

  assign full   = (count_q == CNT_W'(CAP));
  assign wr_idx = count_q[IDX_W-1:0];

  always_comb begin
    do_insert = 1'b0;
    do_shift  = 1'b0;
    status_d  = ST_NOT_FOUND;
    count_d   = count_q;
    fkey_d    = '0;
    finfo_d   = '0;
    fnamel_d  = '0;
    fnameh_d  = '0;
    case (op_q) inside
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_OK;
          do_insert = 1'b1;
          count_d   = count_q + CNT_W'(1);
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (any_hit) begin
          status_d = ST_OK;
          fkey_d   = key_mem_q[hit_idx];
          finfo_d  = info_mem_q[hit_idx];
          fnamel_d = namel_mem_q[hit_idx];
          fnameh_d = nameh_mem_q[hit_idx];
          if (op_q == OP_REMOVE) begin
            do_shift = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
      end
      default: status_d = ST_NOT_FOUND;
    endcase
  end

  for (genvar g = 0; g < CAP; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && do_insert && (wr_idx == IDX_W'(g))) begin
        key_mem_q[g]   <= key_q;
        info_mem_q[g]  <= {year_q, age_q};
        namel_mem_q[g] <= name_low_q;
        nameh_mem_q[g] <= name_high_q;
      end else if (g < CAP - 1) begin
        // advance later records one place toward the head
        if (cmd_i.commit && do_shift && (IDX_W'(g) >= hit_idx)) begin
          key_mem_q[g]   <= key_mem_q[(g + 1) % CAP];
          info_mem_q[g]  <= info_mem_q[(g + 1) % CAP];
          namel_mem_q[g] <= namel_mem_q[(g + 1) % CAP];
          nameh_mem_q[g] <= nameh_mem_q[(g + 1) % CAP];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o          <= status_d;
      count_o           <= count_ext[COUNT_W-1:0];
      found_key_o       <= fkey_d;
      found_year_o      <= finfo_d[INFO_W-1:AGE_W];
      found_age_o       <= finfo_d[AGE_W-1:0];
      found_name_low_o  <= fnamel_d;
      found_name_high_o <= fnameh_d;
    end
  end

  `KRLT_ASSERT(a_count_bounded, count_q <= CNT_W'(CAP))
  `KRLT_ASSERT(a_insert_grows,
               cmd_i.commit && do_insert |=> count_q == $past(count_q) + CNT_W'(1))

endmodule

@@ rtl/core/keyed_record_list_table.sv @@
`timescale 1ns / 1ps
// Keyed record list: an ordered table of up to 16 records (key, year, age,
// ten-character name).
// Requests enter on the s_axis channel: tuser carries the operation
// (insert, search, remove), tdata the record. Each request gives exactly one
// result on the m_axis channel: tuser carries the status (ok, full, not
// found), tdata the entry count after the request and the found or removed
// record (zero for inserts and misses).
// Operation: the request is captured at acceptance; in the execute state the
// key is compared against all live entries in parallel, the table is
// updated (append, or remove with a one-place shift) and the result is
// registered.
// A new request is accepted only in the idle state, after the last one has
// executed, as set by the capture/execute sequence of the controller.
// The result register decouples the sides: a new request is accepted while
// a result waits, but if the receiver stalls the next request waits in the
// execute state until the result register is taken.
// Reset clears the entry count and the handshake state; record storage is
// not cleared, only entries below the count are ever matched or returned.
module keyed_record_list_table
  import krlt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // key, entry_year, entry_age, name_low, name_high (lowest bit up), zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // entry_count, found_key, found_year, found_age, found_name_low,
  // found_name_high (lowest bit up), zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [STAT_W-1:0]     m_axis_tuser
);

  localparam int I_YEAR  = KEY_W;
  localparam int I_AGE   = I_YEAR + YEAR_W;
  localparam int I_NAMEL = I_AGE + AGE_W;
  localparam int I_NAMEH = I_NAMEL + NAMEL_W;

  cmd_t                cmd;
  logic [COUNT_W-1:0]  count;
  logic [KEY_W-1:0]    fkey;
  logic [YEAR_W-1:0]   fyear;
  logic [AGE_W-1:0]    fage;
  logic [NAMEL_W-1:0]  fnamel;
  logic [NAMEH_W-1:0]  fnameh;

  krlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  krlt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .op_i              (s_axis_tuser),
    .key_i             (s_axis_tdata[KEY_W-1:0]),
    .year_i            (s_axis_tdata[I_YEAR +: YEAR_W]),
    .age_i             (s_axis_tdata[I_AGE +: AGE_W]),
    .name_low_i        (s_axis_tdata[I_NAMEL +: NAMEL_W]),
    .name_high_i       (s_axis_tdata[I_NAMEH +: NAMEH_W]),
    .status_o          (m_axis_tuser),
    .count_o           (count),
    .found_key_o       (fkey),
    .found_year_o      (fyear),
    .found_age_o       (fage),
    .found_name_low_o  (fnamel),
    .found_name_high_o (fnameh)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                         fnameh, fnamel, fage, fyear, fkey, count};

endmodule
